@@ src/ostt_pkg.sv @@
// ostt_pkg: shared types, codes and sizes of the one-shot timer table
// no dependencies
`default_nettype none

package ostt_pkg;

	localparam int TIME_W          = 48;
	localparam int DELAY_W         = 32;
	localparam int OWNER_W         = 16;
	localparam int ARG_W           = 32;
	localparam int ACT_W           = 3;
	localparam int KIND_W          = 3;
	localparam int SLOT_W          = 6;
	localparam int MAX_RESULTS     = 32;
	localparam int TABLE_DEPTH_DEF = 32;

	localparam logic [ACT_W-1:0] ACT_SET          = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CANCEL_OWNER = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CANCEL_FIRST = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CANCEL_ALL   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TICK         = 3'd4;

	localparam logic [KIND_W-1:0] KIND_SET_OK       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FULL         = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CANCEL_FOUND = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CANCEL_NONE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EXPIRED      = 3'd4;
	localparam logic [KIND_W-1:0] KIND_TICK_NONE    = 3'd5;

	typedef struct packed {
		logic [ACT_W-1:0]          action;
		logic [DELAY_W-1:0]        delay_ms;
		logic [OWNER_W-1:0]        owner_id;
		logic signed [ARG_W-1:0]   arg_one;
		logic signed [ARG_W-1:0]   arg_two;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [SLOT_W-1:0]         slot;
		logic [OWNER_W-1:0]        fired_owner;
		logic signed [ARG_W-1:0]   fired_arg_one;
		logic signed [ARG_W-1:0]   fired_arg_two;
		logic                      last;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0]  expiry;
		logic [OWNER_W-1:0] owner;
		logic [ARG_W-1:0]   first;
		logic [ARG_W-1:0]   second;
	} entry_t;

	typedef struct packed {
		logic match;
		logic expired;
	} cmp_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SET,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ src/ostt_entry_mem.sv @@
// ostt_entry_mem: timer entry storage, one write and one registered read port
// depends on ostt_pkg
`default_nettype none

module ostt_entry_mem
	import ostt_pkg::*;
#(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/ostt_cmp_unit.sv @@
// ostt_cmp_unit: shared compare unit, key match and expiry test for one entry
// depends on ostt_pkg
`default_nettype none

module ostt_cmp_unit
	import ostt_pkg::*;
(
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [OWNER_W-1:0] owner,
	input  wire logic [ARG_W-1:0]  first,
	input  wire logic [ARG_W-1:0]  second,
	input  wire logic [TIME_W-1:0] now,
	input  wire entry_t            ent,
	output cmp_out_t               res
);

	logic own_eq;
	logic first_eq;
	logic second_eq;

	assign own_eq    = ent.owner == owner;
	assign first_eq  = ent.first == first;
	assign second_eq = ent.second == second;

	always_comb begin
		res.match   = own_eq && (action == ACT_CANCEL_OWNER || first_eq)
			&& (action != ACT_CANCEL_ALL || second_eq);
		res.expired = now >= ent.expiry;
	end

endmodule

`default_nettype wire

@@ src/one_shot_timer_table.sv @@
// one_shot_timer_table: sequencer, live bits and time counter of the timer table
// depends on ostt_pkg, ostt_entry_mem, ostt_cmp_unit
//
// channel  | signals                      | payload
// req      | req_valid, req_ready, req    | req_t: action, delay, owner, arguments
// rsp      | rsp_valid, rsp_ready, rsp    | rsp_t: kind, slot, fired fields, last
//
// set: steps over each occupied slot below the first free one, then writes there
// cancel and tick: step over each free slot, read and then check each live slot
// (single registered read port of the entry memory), then emit the final result
// req_ready is high only while idle; a result waiting in the output register
// does not block the next transfer, the scan stalls only when it must emit
// reset clears live bits, time and control; entry contents need no reset
`default_nettype none

module one_shot_timer_table
	import ostt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = $clog2(MAX_RESULTS + 1);
	localparam logic [IW-1:0] END_IDX  = IW'(TABLE_DEPTH);
	localparam logic [CW-1:0] LAST_CNT = CW'(MAX_RESULTS - 1);
	localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_RESULTS);

	state_t               state_q, state_d;
	req_t                 req_q;
	logic [IW-1:0]        idx_q;
	logic                 found_q;
	logic                 pend_q;
	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        pend_slot_q;
	entry_t               pend_ent_q;
	logic [TIME_W-1:0]    now_q;
	logic [TABLE_DEPTH-1:0] live_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic          acc;
	logic          at_end;
	logic [AW-1:0] slot_idx;
	logic          cur_live;
	logic          out_free;
	logic          is_tick;
	cmp_out_t      hit;
	entry_t        rd_ent;
	entry_t        wr_ent;

	logic mem_re;
	logic mem_we;
	logic idx_inc;
	logic live_set;
	logic live_clr;
	logic found_set;
	logic take;
	logic load_out;
	rsp_t out_d;

	assign req_ready = state_q == ST_IDLE;
	assign acc       = req_valid && req_ready;
	assign at_end    = idx_q == END_IDX;
	assign slot_idx  = idx_q[AW-1:0];
	assign cur_live  = live_q[slot_idx];
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign is_tick   = req_q.action == ACT_TICK;

	always_comb begin
		wr_ent.expiry = now_q + TIME_W'(req_q.delay_ms);
		wr_ent.owner  = req_q.owner_id;
		wr_ent.first  = req_q.arg_one;
		wr_ent.second = req_q.arg_two;
	end

	ostt_entry_mem #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(slot_idx),
		.wdata(wr_ent),
		.re   (mem_re),
		.raddr(slot_idx),
		.rdata(rd_ent)
	);

	ostt_cmp_unit u_cmp (
		.action(req_q.action),
		.owner (req_q.owner_id),
		.first (req_q.arg_one),
		.second(req_q.arg_two),
		.now   (now_q),
		.ent   (rd_ent),
		.res   (hit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (req.action == ACT_SET) begin
						state_d = ST_SET;
					end else if (req.action == ACT_CANCEL_OWNER
						|| req.action == ACT_CANCEL_FIRST
						|| req.action == ACT_CANCEL_ALL
						|| req.action == ACT_TICK) begin
						state_d = ST_READ;
					end
				end
			end
			ST_SET: begin
				if ((at_end || !cur_live) && out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (at_end) begin
					state_d = ST_DONE;
				end else if (cur_live) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (is_tick && hit.expired) begin
					if (!pend_q || out_free) begin
						state_d = (cnt_q == LAST_CNT) ? ST_DONE : ST_READ;
					end
				end else begin
					state_d = ST_READ;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		idx_inc   = 1'b0;
		live_set  = 1'b0;
		live_clr  = 1'b0;
		found_set = 1'b0;
		take      = 1'b0;
		load_out  = 1'b0;
		out_d     = '0;
		case (state_q)
			ST_SET: begin
				if (at_end) begin
					if (out_free) begin
						load_out   = 1'b1;
						out_d.kind = KIND_FULL;
						out_d.last = 1'b1;
					end
				end else if (!cur_live) begin
					if (out_free) begin
						mem_we     = 1'b1;
						live_set   = 1'b1;
						load_out   = 1'b1;
						out_d.kind = KIND_SET_OK;
						out_d.slot = SLOT_W'(slot_idx);
						out_d.last = 1'b1;
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			ST_READ: begin
				if (!at_end) begin
					if (cur_live) begin
						mem_re = 1'b1;
					end else begin
						idx_inc = 1'b1;
					end
				end
			end
			ST_CHECK: begin
				if (is_tick) begin
					if (hit.expired) begin
						if (!pend_q || out_free) begin
							take     = 1'b1;
							live_clr = 1'b1;
							idx_inc  = 1'b1;
						end
						if (pend_q && out_free) begin
							load_out            = 1'b1;
							out_d.kind          = KIND_EXPIRED;
							out_d.slot          = SLOT_W'(pend_slot_q);
							out_d.fired_owner   = pend_ent_q.owner;
							out_d.fired_arg_one = pend_ent_q.first;
							out_d.fired_arg_two = pend_ent_q.second;
						end
					end else begin
						idx_inc = 1'b1;
					end
				end else begin
					idx_inc = 1'b1;
					if (hit.match) begin
						live_clr  = 1'b1;
						found_set = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_out   = 1'b1;
					out_d.last = 1'b1;
					if (!is_tick) begin
						out_d.kind = found_q ? KIND_CANCEL_FOUND : KIND_CANCEL_NONE;
					end else if (pend_q) begin
						out_d.kind          = KIND_EXPIRED;
						out_d.slot          = SLOT_W'(pend_slot_q);
						out_d.fired_owner   = pend_ent_q.owner;
						out_d.fired_arg_one = pend_ent_q.first;
						out_d.fired_arg_two = pend_ent_q.second;
					end else begin
						out_d.kind = KIND_TICK_NONE;
					end
				end
			end
			default: begin
				out_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			found_q     <= 1'b0;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
			now_q       <= '0;
			live_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				pend_q  <= 1'b0;
				cnt_q   <= '0;
				if (req.action == ACT_TICK) begin
					now_q <= now_q + TIME_W'(1);
				end
			end else begin
				if (idx_inc) begin
					idx_q <= idx_q + IW'(1);
				end
				if (found_set) begin
					found_q <= 1'b1;
				end
				if (take) begin
					pend_q <= 1'b1;
					cnt_q  <= cnt_q + CW'(1);
				end
			end
			if (live_set) begin
				live_q[slot_idx] <= 1'b1;
			end else if (live_clr) begin
				live_q[slot_idx] <= 1'b0;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_q <= req;
		end
		if (take) begin
			pend_slot_q <= slot_idx;
			pend_ent_q  <= rd_ent;
		end
		if (load_out) begin
			rsp_q <= out_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_check_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> live_q[slot_idx])
		else $error("entry compared while not live");
	a_set_free: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !live_q[slot_idx])
		else $error("set overwrites a live entry");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("expiry count beyond limit");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> !(state_q == ST_IDLE && $past(load_out)) || rsp_valid)
		else $error("result dropped");
	a_pend_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> cnt_q != '0)
		else $error("pending expiry without count");
`endif

endmodule

`default_nettype wire
